// ----- rtl/core/rde_pkg.sv -----
// rde_pkg: shared widths, the digit step result struct and the quotient width helper
// used by radix_digit_emitter, rde_digit_step and rde_checker; depends on nothing

package rde_pkg;

   localparam int unsigned VALUE_BITS = 32;
   localparam int unsigned RADIX_BITS = 8;
   // a power may pass the value by up to one radix factor
   localparam int unsigned PW_BITS    = VALUE_BITS + RADIX_BITS;
   localparam int unsigned TRIAL_BITS = PW_BITS + RADIX_BITS;
   // one power per digit, at most VALUE_BITS + 1 digits
   localparam int unsigned POW_DEPTH  = VALUE_BITS + 1;
   localparam int unsigned IDX_BITS   = $clog2(POW_DEPTH);
   localparam int unsigned QSEL_BITS  = $clog2(RADIX_BITS);

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);

   // outcome of one compare-subtract step
   typedef struct packed {
      logic                  fit;
      logic [VALUE_BITS-1:0] rem;
   } step_type;

   // index of the top quotient bit a digit below the radix can need
   function automatic logic [QSEL_BITS-1:0] top_qbit(input logic [RADIX_BITS-1:0] max_digit);
      logic [QSEL_BITS-1:0] pos;
      pos = '0;
      for (int i = 0; i < RADIX_BITS; i++) begin
         if (max_digit[i]) begin
            pos = QSEL_BITS'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ----- rtl/core/rde_digit_step.sv -----
// rde_digit_step: shared compare-subtract unit, tests the remainder against a shifted power
// depends on rde_pkg

module rde_digit_step (
   input  logic [rde_pkg::VALUE_BITS-1:0] rem,
   input  logic [rde_pkg::PW_BITS-1:0]    pw,
   input  logic [rde_pkg::QSEL_BITS-1:0]  shamt,
   output rde_pkg::step_type              result
);

   logic [rde_pkg::TRIAL_BITS-1:0] trial;
   logic [rde_pkg::TRIAL_BITS-1:0] rem_wide;

   assign trial    = {{rde_pkg::RADIX_BITS{1'b0}}, pw} << shamt;
   assign rem_wide = {{(rde_pkg::TRIAL_BITS - rde_pkg::VALUE_BITS){1'b0}}, rem};

   always_comb begin
      result.fit = (rem_wide >= trial);
      // trial fits in the remainder width whenever it is subtracted
      result.rem = result.fit ? (rem - trial[rde_pkg::VALUE_BITS-1:0]) : rem;
   end

endmodule

// ----- rtl/core/radix_digit_emitter.sv -----
// radix_digit_emitter: top level, converts an unsigned value to radix digits, msd first
// depends on rde_pkg and rde_digit_step
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    req_value[31:0]
//   rsp       out         rsp_valid/rsp_ready    rsp_digit[7:0], rsp_last_digit
//   csr       in          csr_valid/csr_ready    csr_radix[7:0]
//
// one value at a time: req_ready is high only while no value is in work
// each value runs a power search over S + 1 powers, then per digit a memory read, b
//   quotient bits through the compare-subtract unit and one output transfer, where S is
//   the exponent of the starting power and b the bit width of radix - 1
// powers found in the search sit in a 33-entry memory and are read back downward
// a stalled rsp_ready holds the sequencer in its output state, digit held steady
// synchronous active-high reset: idle, no result pending, radix back to 2

module radix_digit_emitter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rde_pkg::VALUE_BITS-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rde_pkg::RADIX_BITS-1:0] rsp_digit,
   output logic                           rsp_last_digit,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rde_pkg::RADIX_BITS-1:0] csr_radix
);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_DIGIT  = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   localparam int unsigned PROD_BITS = rde_pkg::PW_BITS + rde_pkg::RADIX_BITS;

   logic [2:0]                           state_ff, state_in;
   logic [rde_pkg::RADIX_BITS-1:0]       radix_ff, radix_in;
   logic [rde_pkg::VALUE_BITS-1:0]       rem_ff, rem_in;
   logic [rde_pkg::PW_BITS-1:0]          pw_ff, pw_in;
   logic [rde_pkg::IDX_BITS-1:0]         idx_ff, idx_in;
   logic [rde_pkg::QSEL_BITS-1:0]        qbit_ff, qbit_in;
   logic [rde_pkg::RADIX_BITS-1:0]       dig_ff, dig_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [rde_pkg::RADIX_BITS-1:0]       rsp_digit_ff, rsp_digit_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic [rde_pkg::PW_BITS-1:0]          pw_rd_ff;

   // power table, one entry per digit position
   logic [rde_pkg::PW_BITS-1:0]          pow_mem [rde_pkg::POW_DEPTH];

   logic [rde_pkg::RADIX_BITS-1:0]       radix_eff;
   logic [PROD_BITS-1:0]                 pw_prod;
   logic                                 pw_below;
   logic [rde_pkg::RADIX_BITS-1:0]       dig_next;
   rde_pkg::step_type                    step;

   // radix 0 and 1 run as radix 2
   assign radix_eff = (radix_ff < rde_pkg::RADIX_MIN) ? rde_pkg::RADIX_MIN : radix_ff;

   // next power up; the search stops before it can leave PW_BITS
   assign pw_prod  = {{rde_pkg::RADIX_BITS{1'b0}}, pw_ff}
                   * {{rde_pkg::PW_BITS{1'b0}}, radix_eff};
   assign pw_below = (pw_ff < {{rde_pkg::RADIX_BITS{1'b0}}, rem_ff});

   // shared compare-subtract unit, one quotient bit per cycle in the digit state
   rde_digit_step u_step (
      .rem    (rem_ff),
      .pw     (pw_rd_ff),
      .shamt  (qbit_ff),
      .result (step)
   );

   assign dig_next = dig_ff | (rde_pkg::RADIX_BITS'(step.fit) << qbit_ff);

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = rsp_digit_ff;
   assign rsp_last_digit = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      rem_in       = rem_ff;
      pw_in        = pw_ff;
      idx_in       = idx_ff;
      qbit_in      = qbit_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;

      // the user must keep config to arrive only while idle; the block itself does not enforce it
      if (csr_valid) begin
         radix_in = csr_radix;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rem_in   = req_value;
               pw_in    = rde_pkg::PW_BITS'(1);
               idx_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // current power is stored this cycle at idx
            if (pw_below) begin
               pw_in  = pw_prod[rde_pkg::PW_BITS-1:0];
               idx_in = idx_ff + rde_pkg::IDX_BITS'(1);
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // power for this digit lands in pw_rd_ff at the edge
            qbit_in  = rde_pkg::top_qbit(radix_eff - rde_pkg::RADIX_BITS'(1));
            dig_in   = '0;
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            rem_in = step.rem;
            dig_in = dig_next;
            if (qbit_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = dig_next;
               rsp_last_in  = (idx_ff == '0);
               state_in     = ST_EMIT;
            end else begin
               qbit_in = qbit_ff - rde_pkg::QSEL_BITS'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - rde_pkg::IDX_BITS'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= rde_pkg::RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      pw_ff        <= pw_in;
      idx_ff       <= idx_in;
      qbit_ff      <= qbit_in;
      dig_ff       <= dig_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // power memory: written during the search, read back one digit at a time
   always_ff @(posedge clock) begin
      if (state_ff == ST_SEARCH) begin
         pow_mem[idx_ff] <= pw_ff;
      end
      pw_rd_ff <= pow_mem[idx_ff];
   end

endmodule

// ----- rtl/core/rde_checker.sv -----
// rde_checker: port-level checks for radix_digit_emitter, attached by bind
// depends on rde_pkg for port widths

module rde_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rde_pkg::RADIX_BITS-1:0] rsp_digit,
   input logic                           rsp_last_digit
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit) && $stable(rsp_last_digit))
      else $error("rsp payload changed while stalled");

   // no new value is taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req ready while rsp pending");

   // an accepted value closes the input until its digits are done
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready right after a transfer");

   // the final digit frees the input
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_digit |=> req_ready && !rsp_valid)
      else $error("not idle after last digit");

   // more digits follow a non-final one
   a_more_after_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_digit |=> !req_ready)
      else $error("idle before last digit");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_digit      (rsp_digit),
   .rsp_last_digit (rsp_last_digit)
);
